@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the converter, included by the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/yuyv_rgb_pkg.sv @@
// Constants, types and arithmetic helpers for the YUYV to packed RGB10 converter.
`default_nettype none

package yuyv_rgb_pkg;

  // Fixed-point coefficient width and working sum width
  localparam int unsigned CoefW = 15;
  localparam int unsigned SumW  = 24;
  localparam int unsigned FracBits = 10;
  localparam int unsigned ChanW = 10;

  localparam logic [7:0] LumaOffset = 8'd16;
  localparam logic [ChanW-1:0] ChanMax = 10'h3FF;
  localparam logic [1:0] AlphaCode = 2'd3;

  // Coefficients (G chroma terms are subtracted)
  localparam logic signed [CoefW-1:0] CoefBY = 15'sd4768;
  localparam logic signed [CoefW-1:0] CoefBU = 15'sd8809;
  localparam logic signed [CoefW-1:0] CoefBV = 15'sd11;
  localparam logic signed [CoefW-1:0] CoefGY = 15'sd4826;
  localparam logic signed [CoefW-1:0] CoefGU = 15'sd775;
  localparam logic signed [CoefW-1:0] CoefGV = 15'sd2670;
  localparam logic signed [CoefW-1:0] CoefRY = 15'sd4778;
  localparam logic signed [CoefW-1:0] CoefRU = 15'sd2;
  localparam logic signed [CoefW-1:0] CoefRV = 15'sd6931;

  typedef logic signed [SumW-1:0] sum_t;

  // Luma products of one pixel
  typedef struct packed {
    sum_t b;
    sum_t g;
    sum_t r;
  } luma_prod_t;

  // Chroma products shared by both pixels
  typedef struct packed {
    sum_t bu;
    sum_t bv;
    sum_t gu;
    sum_t gv;
    sum_t ru;
    sum_t rv;
  } chroma_prod_t;

  // Channel sums of one pixel
  typedef struct packed {
    sum_t b;
    sum_t g;
    sum_t r;
  } pix_sum_t;

  // Flags that ride along with each beat
  typedef struct packed {
    logic single_pixel;
    logic frame_end;
  } beat_flags_t;

  // Signed 9-bit value times a constant coefficient
  function automatic sum_t mul_coef(logic signed [8:0] x, logic signed [CoefW-1:0] c);
    sum_t xe;
    sum_t ce;
    xe = SumW'(x);
    ce = SumW'(c);
    return xe * ce;
  endfunction

  // Floor shift then clamp to 0..1023
  function automatic logic [ChanW-1:0] clamp_chan(sum_t s);
    logic [ChanW-1:0] res;
    if (s[SumW-1]) begin
      res = '0;
    end else if (|s[SumW-2:FracBits+ChanW]) begin
      res = ChanMax;
    end else begin
      res = s[FracBits+ChanW-1:FracBits];
    end
    return res;
  endfunction

  // alpha 1:0, R 11:2, G 21:12, B 31:22
  function automatic logic [31:0] pack_pix(pix_sum_t s);
    return {clamp_chan(s.b), clamp_chan(s.g), clamp_chan(s.r), AlphaCode};
  endfunction

endpackage

`default_nettype wire

@@ sv/yuyv_to_rgb10_packed.sv @@
// Top level: four-stage YUYV macropixel to packed RGB10 converter.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   luma_first, chroma_blue, luma_second,
//                                           chroma_red, single_pixel, frame_end
//   out      out  out_valid_o / out_stall_i word_first, word_second,
//                                           second_valid, frame_done
//
// The four register stages are offset, multiply, sum and clamp/pack; one beat per
// cycle is sustained while the output is not stalled.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under stall and no beat is dropped or repeated.
// Reset (rst_ni low) empties every stage; payload registers are not reset.
`default_nettype none

module yuyv_to_rgb10_packed (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  luma_first_i,
  input  wire logic [7:0]  chroma_blue_i,
  input  wire logic [7:0]  luma_second_i,
  input  wire logic [7:0]  chroma_red_i,
  input  wire logic        single_pixel_i,
  input  wire logic        frame_end_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] word_first_o,
  output      logic [31:0] word_second_o,
  output      logic        second_valid_o,
  output      logic        frame_done_o
);

`include "assert_macros.svh"

  // Stage valids
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic ld1, ld2, ld3, ld_out;

  // Stage 1: offset-removed samples
  logic signed [8:0] y0_q, y1_q, u_q, v_q;
  yuyv_rgb_pkg::beat_flags_t s1_flags_q;

  // Stage 2: products
  yuyv_rgb_pkg::luma_prod_t   p0_q, p1_q;
  yuyv_rgb_pkg::chroma_prod_t pc_q;
  yuyv_rgb_pkg::beat_flags_t  s2_flags_q;

  // Stage 3: channel sums
  yuyv_rgb_pkg::pix_sum_t    sum0_q, sum1_q;
  yuyv_rgb_pkg::beat_flags_t s3_flags_q;

  // Output registers
  logic [31:0] word_first_q, word_second_q;
  logic        second_valid_q, frame_done_q;

  // Load enables, back to front
  assign ld_out = !out_valid_q || !out_stall_i;
  assign ld3    = !s3_valid_q || ld_out;
  assign ld2    = !s2_valid_q || ld3;
  assign ld1    = !s1_valid_q || ld2;
  assign in_stall_o = !ld1;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1)    s1_valid_q  <= in_valid_i;
      if (ld2)    s2_valid_q  <= s1_valid_q;
      if (ld3)    s3_valid_q  <= s2_valid_q;
      if (ld_out) out_valid_q <= s3_valid_q;
    end
  end

  // Stage 1: remove luma and chroma offsets (chroma - 128 is an MSB flip)
  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      y0_q <= $signed({1'b0, luma_first_i}) - $signed({1'b0, yuyv_rgb_pkg::LumaOffset});
      y1_q <= $signed({1'b0, luma_second_i}) - $signed({1'b0, yuyv_rgb_pkg::LumaOffset});
      u_q  <= $signed({~chroma_blue_i[7], ~chroma_blue_i[7], chroma_blue_i[6:0]});
      v_q  <= $signed({~chroma_red_i[7], ~chroma_red_i[7], chroma_red_i[6:0]});
      s1_flags_q <= '{single_pixel: single_pixel_i, frame_end: frame_end_i};
    end
  end

  // Stage 2: constant-coefficient products
  always_ff @(posedge clk_i) begin
    if (ld2 && s1_valid_q) begin
      p0_q.b <= yuyv_rgb_pkg::mul_coef(y0_q, yuyv_rgb_pkg::CoefBY);
      p0_q.g <= yuyv_rgb_pkg::mul_coef(y0_q, yuyv_rgb_pkg::CoefGY);
      p0_q.r <= yuyv_rgb_pkg::mul_coef(y0_q, yuyv_rgb_pkg::CoefRY);
      p1_q.b <= yuyv_rgb_pkg::mul_coef(y1_q, yuyv_rgb_pkg::CoefBY);
      p1_q.g <= yuyv_rgb_pkg::mul_coef(y1_q, yuyv_rgb_pkg::CoefGY);
      p1_q.r <= yuyv_rgb_pkg::mul_coef(y1_q, yuyv_rgb_pkg::CoefRY);
      pc_q.bu <= yuyv_rgb_pkg::mul_coef(u_q, yuyv_rgb_pkg::CoefBU);
      pc_q.bv <= yuyv_rgb_pkg::mul_coef(v_q, yuyv_rgb_pkg::CoefBV);
      pc_q.gu <= yuyv_rgb_pkg::mul_coef(u_q, yuyv_rgb_pkg::CoefGU);
      pc_q.gv <= yuyv_rgb_pkg::mul_coef(v_q, yuyv_rgb_pkg::CoefGV);
      pc_q.ru <= yuyv_rgb_pkg::mul_coef(u_q, yuyv_rgb_pkg::CoefRU);
      pc_q.rv <= yuyv_rgb_pkg::mul_coef(v_q, yuyv_rgb_pkg::CoefRV);
      s2_flags_q <= s1_flags_q;
    end
  end

  // Stage 3: three-term sums per channel
  always_ff @(posedge clk_i) begin
    if (ld3 && s2_valid_q) begin
      sum0_q.b <= p0_q.b + pc_q.bu + pc_q.bv;
      sum0_q.g <= p0_q.g - pc_q.gu - pc_q.gv;
      sum0_q.r <= p0_q.r + pc_q.ru + pc_q.rv;
      sum1_q.b <= p1_q.b + pc_q.bu + pc_q.bv;
      sum1_q.g <= p1_q.g - pc_q.gu - pc_q.gv;
      sum1_q.r <= p1_q.r + pc_q.ru + pc_q.rv;
      s3_flags_q <= s2_flags_q;
    end
  end

  // Stage 4: clamp, pack, blank the unused second pixel
  always_ff @(posedge clk_i) begin
    if (ld_out && s3_valid_q) begin
      word_first_q   <= yuyv_rgb_pkg::pack_pix(sum0_q);
      word_second_q  <= s3_flags_q.single_pixel ? 32'd0 : yuyv_rgb_pkg::pack_pix(sum1_q);
      second_valid_q <= !s3_flags_q.single_pixel;
      frame_done_q   <= s3_flags_q.frame_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_first_o   = word_first_q;
  assign word_second_o  = word_second_q;
  assign second_valid_o = second_valid_q;
  assign frame_done_o   = frame_done_q;

  // Backpressure only when every stage is full and the sink stalls
  `ASSERT_NOW(a_stall_full, in_stall_o,
              s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q && out_stall_i,
              "input stalled while pipeline has a bubble")

  // Unused second pixel reads as zero
  `ASSERT_NOW(a_second_blank, out_valid_o && !second_valid_o, word_second_o == 32'd0,
              "second word not blanked for single-pixel beat")

  // A beat in stage 3 that the output takes shows up on the output next cycle
  `ASSERT_NEXT(a_s3_to_out, s3_valid_q && ld_out,
               out_valid_o && word_first_o[1:0] == yuyv_rgb_pkg::AlphaCode,
               "stage 3 beat did not reach the output register")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the YUYV macropixel to packed RGB10 converter.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LumaBias    = 16;
  localparam int ChromaBias  = 128;
  localparam int ShiftBits   = 10;
  localparam int ChannelTop  = 'h3FF;
  localparam bit [1:0] AlphaOpaque = 2'd3;

  // Conversion coefficients per channel
  localparam int KBlueY  = 4768;
  localparam int KBlueU  = 8809;
  localparam int KBlueV  = 11;
  localparam int KGreenY = 4826;
  localparam int KGreenU = 775;
  localparam int KGreenV = 2670;
  localparam int KRedY   = 4778;
  localparam int KRedU   = 2;
  localparam int KRedV   = 6931;

  localparam int RandomBeats  = 1830;
  localparam int CalmBeats    = 200;
  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 12;
  localparam int ReportLimit  = 10;

  typedef struct {
    bit [31:0] word_first;
    bit [31:0] word_second;
    bit        second_valid;
    bit        frame_done;
  } rgb_pair_t;

  // Predicts packed pixel pairs and compares them with the output beats
  class rgb_scoreboard;
    rgb_pair_t pending_pairs[$];
    int unsigned mismatches;

    function int clamp_to_channel(int sum);
      int shifted;
      if (sum < 0) return 0;
      shifted = sum >>> ShiftBits;
      if (shifted > ChannelTop) return ChannelTop;
      return shifted;
    endfunction

    function bit [31:0] convert_pixel(bit [7:0] luma, int u, int v);
      int y;
      int b;
      int g;
      int r;
      y = int'(luma) - LumaBias;
      b = clamp_to_channel(KBlueY * y + KBlueU * u + KBlueV * v);
      g = clamp_to_channel(KGreenY * y - KGreenU * u - KGreenV * v);
      r = clamp_to_channel(KRedY * y + KRedU * u + KRedV * v);
      return {b[9:0], g[9:0], r[9:0], AlphaOpaque};
    endfunction

    function void note_macropixel(bit [7:0] luma_a, bit [7:0] cb, bit [7:0] luma_b,
                                  bit [7:0] cr, bit single, bit last);
      rgb_pair_t pair;
      int u;
      int v;
      u = int'(cb) - ChromaBias;
      v = int'(cr) - ChromaBias;
      pair.word_first   = convert_pixel(luma_a, u, v);
      // odd-width tail: second word is forced to zero
      pair.word_second  = single ? 32'd0 : convert_pixel(luma_b, u, v);
      pair.second_valid = !single;
      pair.frame_done   = last;
      pending_pairs.push_back(pair);
    endfunction

    function void check_pair(logic [31:0] w_a, logic [31:0] w_b, logic sv, logic fd);
      rgb_pair_t want;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] unexpected beat: first=%h second=%h sv=%b fd=%b",
                   $realtime, w_a, w_b, sv, fd);
        return;
      end
      want = pending_pairs.pop_front();
      if (w_a !== want.word_first || w_b !== want.word_second ||
          sv !== want.second_valid || fd !== want.frame_done) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] mismatch: exp first=%h second=%h sv=%b fd=%b, got %h %h %b %b",
                   $realtime, want.word_first, want.word_second, want.second_valid,
                   want.frame_done, w_a, w_b, sv, fd);
      end
    endfunction

    function int pending_count();
      return pending_pairs.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  luma_first_i;
  logic [7:0]  chroma_blue_i;
  logic [7:0]  luma_second_i;
  logic [7:0]  chroma_red_i;
  logic        single_pixel_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] word_first_o;
  logic [31:0] word_second_o;
  logic        second_valid_o;
  logic        frame_done_o;

  rgb_scoreboard sb;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;

  yuyv_to_rgb10_packed u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .luma_first_i   (luma_first_i),
    .chroma_blue_i  (chroma_blue_i),
    .luma_second_i  (luma_second_i),
    .chroma_red_i   (chroma_red_i),
    .single_pixel_i (single_pixel_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .word_first_o   (word_first_o),
    .word_second_o  (word_second_o),
    .second_valid_o (second_valid_o),
    .frame_done_o   (frame_done_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** yuyv_to_rgb10_packed: FAILED **");
      $finish;
    end
  end

  // Output stall in random bursts, none once the run goes calm
  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_pair(word_first_o, word_second_o, second_valid_o, frame_done_o);
  end

  // Present one macropixel beat and hold it until accepted
  task automatic drive_macropixel(bit [7:0] luma_a, bit [7:0] cb, bit [7:0] luma_b,
                                  bit [7:0] cr, bit single, bit last);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    luma_first_i   <= luma_a;
    chroma_blue_i  <= cb;
    luma_second_i  <= luma_b;
    chroma_red_i   <= cr;
    single_pixel_i <= single;
    frame_end_i    <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_macropixel(luma_a, cb, luma_b, cr, single, last);
  endtask

  // Input gap: in_valid_i held low, its length set by n
  task automatic pause_input(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Byte biased toward the ends of the range and the video levels
  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 24));
      3:       return 8'($urandom_range(230, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    sb = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    luma_first_i   = '0;
    chroma_blue_i  = '0;
    luma_second_i  = '0;
    chroma_red_i   = '0;
    single_pixel_i = 1'b0;
    frame_end_i    = 1'b0;
    out_stall_i    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: range ends, video levels, clamping both ways, tail and last flags
    drive_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
    drive_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    drive_macropixel(8'd16,  8'd128, 8'd16,  8'd128, 1'b0, 1'b0);
    drive_macropixel(8'd235, 8'd128, 8'd235, 8'd128, 1'b0, 1'b0);
    drive_macropixel(8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 1'b0);
    drive_macropixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 1'b0);
    drive_macropixel(8'd16,  8'd0,   8'd235, 8'd0,   1'b0, 1'b0);
    drive_macropixel(8'd255, 8'd128, 8'd0,   8'd128, 1'b0, 1'b0);
    drive_macropixel(8'd128, 8'd255, 8'd128, 8'd255, 1'b0, 1'b0);
    drive_macropixel(8'd81,  8'd90,  8'd145, 8'd240, 1'b0, 1'b0);
    drive_macropixel(8'd170, 8'd166, 8'd41,  8'd16,  1'b0, 1'b0);
    drive_macropixel(8'd15,  8'd127, 8'd17,  8'd129, 1'b0, 1'b0);
    drive_macropixel(8'd200, 8'd60,  8'd77,  8'd220, 1'b1, 1'b0);
    drive_macropixel(8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 1'b0);
    drive_macropixel(8'd255, 8'd255, 8'd0,   8'd0,   1'b1, 1'b1);
    drive_macropixel(8'd100, 8'd128, 8'd50,  8'd128, 1'b0, 1'b1);
    drive_macropixel(8'd170, 8'd85,  8'd85,  8'd170, 1'b0, 1'b0);
    drive_macropixel(8'd85,  8'd170, 8'd170, 8'd85,  1'b1, 1'b1);
    pause_input(3);

    // Random beats, gaps and stalls until the calm tail
    for (int i = 0; i < RandomBeats; i++) begin
      if (i >= RandomBeats - CalmBeats) calm = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 8));
      drive_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then keep watching the output to catch stray beats
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("** yuyv_to_rgb10_packed: PASSED **");
    end else begin
      $display("** yuyv_to_rgb10_packed: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
